>>> design/iidb_pkg.sv
// ----------------------------------------------------------------------------
// Integer division bounds package
// Shared types, constants and helper functions for the division bounds block.
// ----------------------------------------------------------------------------
package iidb_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned DivSteps = DataW;

  localparam logic signed [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};

  typedef logic [1:0] op_idx_t;
  localparam op_idx_t LastOp = 2'd3;

  // One item after classification, as held in the queue.
  typedef struct packed {
    logic signed [DataW-1:0] num_lower;
    logic signed [DataW-1:0] num_upper;
    logic signed [DataW-1:0] den_lower;
    logic signed [DataW-1:0] den_upper;
    logic                    lower_use;
    logic                    upper_use;
    logic signed [DataW-1:0] seed_lo;
    logic signed [DataW-1:0] seed_hi;
    logic                    widen;
    logic                    invalid;
  } entry_t;

  // One division in flight through the divider pipeline.
  typedef struct packed {
    logic                    valid;
    logic [DataW-1:0]        quo;
    logic [DataW-1:0]        rem;
    logic [DataW-1:0]        dvs;
    logic                    neg;
    logic                    use_q;
    logic                    first;
    logic                    last;
    logic signed [DataW-1:0] seed_lo;
    logic signed [DataW-1:0] seed_hi;
    logic                    widen;
    logic                    invalid;
  } stage_t;

  function automatic logic signed [DataW-1:0] sat_neg(input logic signed [DataW-1:0] x);
    sat_neg = (x == MinVal) ? MaxVal : -x;
  endfunction

  function automatic logic signed [DataW-1:0] smin(input logic signed [DataW-1:0] a,
                                                   input logic signed [DataW-1:0] b);
    smin = (a < b) ? a : b;
  endfunction

  function automatic logic signed [DataW-1:0] smax(input logic signed [DataW-1:0] a,
                                                   input logic signed [DataW-1:0] b);
    smax = (a > b) ? a : b;
  endfunction

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic stage_t div_step(input stage_t s);
    stage_t         o;
    logic [DataW:0] t;
    logic [DataW:0] diff;
    logic           ge;
    o    = s;
    t    = {s.rem, s.quo[DataW-1]};
    diff = t - {1'b0, s.dvs};
    ge   = (t >= {1'b0, s.dvs});
    o.rem = ge ? diff[DataW-1:0] : t[DataW-1:0];
    o.quo = {s.quo[DataW-2:0], ge};
    div_step = o;
  endfunction

endpackage

>>> design/iidb_if.sv
// ----------------------------------------------------------------------------
// Division bounds channels
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface iidb_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] num_lower;
  logic signed [63:0] num_upper;
  logic signed [63:0] den_lower;
  logic signed [63:0] den_upper;
  logic               widen_request;

  modport source (output valid, num_lower, num_upper, den_lower, den_upper, widen_request,
                  input ready);
  modport sink (input valid, num_lower, num_upper, den_lower, den_upper, widen_request,
                output ready);
endinterface

interface iidb_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] quot_lower;
  logic signed [63:0] quot_upper;
  logic               widen_echo;
  logic               invalid_flag;

  modport source (output valid, quot_lower, quot_upper, widen_echo, invalid_flag,
                  input ready);
  modport sink (input valid, quot_lower, quot_upper, widen_echo, invalid_flag,
                output ready);
endinterface

>>> design/interval_int_div_bounds.sv
// ----------------------------------------------------------------------------
// Interval integer division bounds
// Computes truncating quotient bounds of a numerator interval divided by a
// denominator interval.
// ----------------------------------------------------------------------------
// Usage:
// An operand item on in_ch carries the numerator and denominator bounds and
// the widen flag; it is taken when valid and ready are both high. One result
// item per operand item appears on out_ch, in order, as a valid/ready transfer.
// The front end classifies the item into a two-entry queue. The back end
// issues four divisions per item, one per cycle unless the output stalls,
// into a 64-stage pipelined divider; the next item starts issuing once the
// last division of the previous one has issued, while that one is still in
// the divider. Each result leaves the divider through the output register.
// Unit divisors are folded in by the front end without the divider.
// Reset clears the queue, the pipeline valid bits and the output valid bit.
// While the receiver holds ready low with a result waiting, the divider
// pipeline freezes; the queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
module interval_int_div_bounds (
  input  logic       clk,
  input  logic       rst_n,
  iidb_in_if.sink    in_ch,
  iidb_out_if.source out_ch
);
  import iidb_pkg::*;

  entry_t push_data;
  entry_t head_data;
  logic   push;
  logic   push_ready;
  logic   pop;
  logic   head_valid;

  iidb_front u_front (
    .in_ch   (in_ch),
    .q_ready (push_ready),
    .q_push  (push),
    .q_data  (push_data)
  );

  iidb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  iidb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

>>> design/iidb_front.sv
// ----------------------------------------------------------------------------
// Division bounds front end
// Accepts operand items, picks the candidate divisors and folds the unit
// divisors into a starting bound pair.
// ----------------------------------------------------------------------------
module iidb_front (
  iidb_in_if.sink         in_ch,
  input  logic            q_ready,
  output logic            q_push,
  output iidb_pkg::entry_t q_data
);
  import iidb_pkg::*;

  logic pos_one;
  logic neg_one;
  logic signed [DataW-1:0] lo_a;
  logic signed [DataW-1:0] hi_a;

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;

  always_comb begin
    pos_one = (in_ch.den_lower <= 0) && (in_ch.den_upper > 0);
    neg_one = (in_ch.den_lower < 0) && (in_ch.den_upper >= 0);
    lo_a = pos_one ? smin(in_ch.num_lower, in_ch.num_upper) : MaxVal;
    hi_a = pos_one ? smax(in_ch.num_lower, in_ch.num_upper) : MinVal;
    q_data.num_lower = in_ch.num_lower;
    q_data.num_upper = in_ch.num_upper;
    q_data.den_lower = in_ch.den_lower;
    q_data.den_upper = in_ch.den_upper;
    q_data.lower_use = (in_ch.den_lower != 0);
    q_data.upper_use = (in_ch.den_upper != 0);
    q_data.seed_lo = neg_one ?
        smin(lo_a, smin(sat_neg(in_ch.num_lower), sat_neg(in_ch.num_upper))) : lo_a;
    q_data.seed_hi = neg_one ?
        smax(hi_a, smax(sat_neg(in_ch.num_lower), sat_neg(in_ch.num_upper))) : hi_a;
    q_data.widen   = in_ch.widen_request;
    q_data.invalid = (in_ch.den_lower == 0) && (in_ch.den_upper == 0);
  end

endmodule

>>> design/iidb_queue.sv
// ----------------------------------------------------------------------------
// Division bounds queue
// Two-entry queue between the front end and the divider back end.
// ----------------------------------------------------------------------------
module iidb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  iidb_pkg::entry_t push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             head_valid,
  output iidb_pkg::entry_t head_data
);
  import iidb_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign push_ready = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> design/iidb_back.sv
// ----------------------------------------------------------------------------
// Division bounds back end
// Issues the four numerator/divisor pairs of an item into a 64-stage divider
// pipeline and folds the quotients into the result bounds.
// ----------------------------------------------------------------------------
module iidb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  iidb_pkg::entry_t head_data,
  output logic             pop,
  iidb_out_if.source       out_ch
);
  import iidb_pkg::*;

  stage_t  pipe_r  [DivSteps];
  stage_t  pipe_in [DivSteps];
  stage_t  issue;
  op_idx_t op_cnt_r;
  op_idx_t op_cnt_nxt;
  logic    en;

  logic signed [DataW-1:0] num;
  logic signed [DataW-1:0] den;
  logic signed [DataW-1:0] q;
  logic signed [DataW-1:0] base_lo;
  logic signed [DataW-1:0] base_hi;
  logic signed [DataW-1:0] new_lo;
  logic signed [DataW-1:0] new_hi;
  logic signed [DataW-1:0] acc_lo_r;
  logic signed [DataW-1:0] acc_hi_r;
  logic signed [DataW-1:0] out_lo_r;
  logic signed [DataW-1:0] out_hi_r;
  logic                    out_widen_r;
  logic                    out_invalid_r;
  logic                    out_valid_r;
  stage_t                  tail;

  assign en  = !out_valid_r || out_ch.ready;
  assign pop = head_valid && en && (op_cnt_r == LastOp);

  always_comb begin
    op_cnt_nxt = op_cnt_r;
    if (head_valid && en) begin
      op_cnt_nxt = op_cnt_r + 2'd1;
    end
    num = op_cnt_r[0] ? head_data.num_upper : head_data.num_lower;
    den = op_cnt_r[1] ? head_data.den_upper : head_data.den_lower;
    issue.valid   = head_valid;
    issue.quo     = num[DataW-1] ? -num : num;
    issue.rem     = '0;
    issue.dvs     = den[DataW-1] ? -den : den;
    issue.neg     = num[DataW-1] ^ den[DataW-1];
    issue.use_q   = op_cnt_r[1] ? head_data.upper_use : head_data.lower_use;
    issue.first   = (op_cnt_r == '0);
    issue.last    = (op_cnt_r == LastOp);
    issue.seed_lo = head_data.seed_lo;
    issue.seed_hi = head_data.seed_hi;
    issue.widen   = head_data.widen;
    issue.invalid = head_data.invalid;
  end

  always_comb begin
    pipe_in[0] = issue;
    for (int i = 1; i < DivSteps; i++) begin
      pipe_in[i] = pipe_r[i-1];
    end
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[g].valid <= 1'b0;
      end else if (en) begin
        pipe_r[g] <= div_step(pipe_in[g]);
      end
    end
  end

  always_comb begin
    tail = pipe_r[DivSteps-1];
    if (tail.neg) begin
      q = -tail.quo;
    end else if (tail.quo[DataW-1]) begin
      q = MaxVal;
    end else begin
      q = tail.quo;
    end
    base_lo = tail.first ? tail.seed_lo : acc_lo_r;
    base_hi = tail.first ? tail.seed_hi : acc_hi_r;
    new_lo  = (tail.use_q && (q < base_lo)) ? q : base_lo;
    new_hi  = (tail.use_q && (q > base_hi)) ? q : base_hi;
  end

  always_ff @(posedge clk) begin
    if (en && tail.valid) begin
      acc_lo_r <= new_lo;
      acc_hi_r <= new_hi;
      if (tail.last) begin
        out_lo_r      <= tail.invalid ? '0 : new_lo;
        out_hi_r      <= tail.invalid ? '0 : new_hi;
        out_widen_r   <= tail.widen;
        out_invalid_r <= tail.invalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      op_cnt_r <= op_cnt_nxt;
      if (en && tail.valid && tail.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.quot_lower   = out_lo_r;
  assign out_ch.quot_upper   = out_hi_r;
  assign out_ch.widen_echo   = out_widen_r;
  assign out_ch.invalid_flag = out_invalid_r;

  a_cnt_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    op_cnt_r != '0 |-> head_valid)
    else $error("operation counter runs without a queued item");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(pipe_r[DivSteps-1].valid))
    else $error("divider pipeline moved during an output stall");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_invalid_r |-> out_lo_r == '0 && out_hi_r == '0)
    else $error("invalid result carries nonzero bounds");

  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> op_cnt_r == '0)
    else $error("item left the queue before its last operation");

endmodule

>>> tb/iidb_tb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Division bounds checker
// Watches both channels, computes the expected quotient bounds of every
// operand transfer and compares each result transfer against the oldest one.
// ----------------------------------------------------------------------------
module iidb_tb_checker (
  input  logic      clk,
  input  logic      rst_n,
  iidb_in_if.sink   in_mon,
  iidb_out_if.sink  out_mon,
  output int        fail_count,
  output int        pending_count
);
  import iidb_pkg::*;

  typedef struct packed {
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic               widen;
    logic               invalid;
  } bounds_t;

  bounds_t expected_bounds[$];

  function automatic logic signed [63:0] trunc_quot(logic signed [63:0] a,
                                                    logic signed [63:0] d);
    if (d == -64'sd1) begin
      return (a == MinVal) ? MaxVal : -a;
    end
    return a / d;
  endfunction

  function automatic bounds_t div_bounds(logic signed [63:0] nl, logic signed [63:0] nu,
                                         logic signed [63:0] dl, logic signed [63:0] du,
                                         logic w);
    bounds_t            r;
    logic signed [63:0] divs[$];
    logic signed [63:0] q1;
    logic signed [63:0] q2;
    r.lo = MaxVal;
    r.hi = MinVal;
    r.widen = w;
    r.invalid = 1'b0;
    if (dl <= 0 && du > 0) divs.push_back(64'sd1);
    if (dl < 0 && du >= 0) divs.push_back(-64'sd1);
    if (dl != 0) divs.push_back(dl);
    if (du != 0) divs.push_back(du);
    foreach (divs[k]) begin
      q1 = trunc_quot(nl, divs[k]);
      q2 = trunc_quot(nu, divs[k]);
      if (q1 < r.lo) r.lo = q1;
      if (q2 < r.lo) r.lo = q2;
      if (q1 > r.hi) r.hi = q1;
      if (q2 > r.hi) r.hi = q2;
    end
    if (divs.size() == 0) begin
      r.lo = '0;
      r.hi = '0;
      r.invalid = 1'b1;
    end
    return r;
  endfunction

  assign pending_count = expected_bounds.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    bounds_t e;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        expected_bounds.push_back(div_bounds(in_mon.num_lower, in_mon.num_upper,
                                             in_mon.den_lower, in_mon.den_upper,
                                             in_mon.widen_request));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bounds.size() == 0) begin
          $error("result transfer with no expectation waiting");
          fail_count++;
        end else begin
          e = expected_bounds.pop_front();
          if (out_mon.quot_lower !== e.lo) begin
            $error("quot_lower: expected %0d, actual %0d", e.lo, out_mon.quot_lower);
            fail_count++;
          end
          if (out_mon.quot_upper !== e.hi) begin
            $error("quot_upper: expected %0d, actual %0d", e.hi, out_mon.quot_upper);
            fail_count++;
          end
          if (out_mon.widen_echo !== e.widen) begin
            $error("widen_echo: expected %0b, actual %0b", e.widen, out_mon.widen_echo);
            fail_count++;
          end
          if (out_mon.invalid_flag !== e.invalid) begin
            $error("invalid_flag: expected %0b, actual %0b", e.invalid,
                   out_mon.invalid_flag);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Division bounds testbench
// Sends directed corner cases and random operand intervals through the block
// under four phases of sender idling and receiver stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import iidb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  iidb_in_if  in_ch();
  iidb_out_if out_ch();

  interval_int_div_bounds u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  iidb_tb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.num_lower = '0;
    in_ch.num_upper = '0;
    in_ch.den_lower = '0;
    in_ch.den_upper = '0;
    in_ch.widen_request = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic signed [63:0] rand_bound();
    logic signed [63:0] v;
    case ($urandom_range(7))
      0: v = MinVal + $urandom_range(2);
      1: v = MaxVal - $urandom_range(2);
      2, 3: v = $signed(64'($urandom_range(8))) - 4;
      4: v = $signed(64'($urandom_range(2000))) - 1000;
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  task automatic send_item(logic signed [63:0] nl, logic signed [63:0] nu,
                           logic signed [63:0] dl, logic signed [63:0] du, logic w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.num_lower <= nl;
    in_ch.num_upper <= nu;
    in_ch.den_lower <= dl;
    in_ch.den_upper <= du;
    in_ch.widen_request <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] c;
    logic signed [63:0] d;
    a = rand_bound();
    b = rand_bound();
    c = rand_bound();
    d = rand_bound();
    if ($urandom_range(3) != 0) begin
      if (a > b) begin a = a ^ b; b = a ^ b; a = a ^ b; end
      if (c > d) begin c = c ^ d; d = c ^ d; c = c ^ d; end
    end
    send_item(a, b, c, d, 1'($urandom()));
  endtask

  initial begin
    int phase_idle[4] = '{0, 50, 0, 19};
    int phase_stall[4] = '{0, 0, 50, 19};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_item(100, 200, 0, 0, 1'b1);
    send_item(MinVal, MaxVal, -1, -1, 1'b0);
    send_item(MinVal, MinVal, -1, 1, 1'b1);
    send_item(MinVal, MaxVal, MinVal, MaxVal, 1'b0);
    send_item(MaxVal, MinVal, MaxVal, MinVal, 1'b1);
    send_item(-7, 7, 0, 3, 1'b0);
    send_item(-7, 7, -3, 0, 1'b1);
    send_item(-7, 7, -3, 3, 1'b0);
    send_item(7, -7, 3, -3, 1'b1);
    send_item(5, 9, 1, 1, 1'b0);
    send_item(5, 9, 2, 2, 1'b0);
    send_item(-9, -5, -2, -2, 1'b1);
    send_item(MaxVal, MaxVal, MinVal, MinVal, 1'b0);
    send_item(-64'sd1, -64'sd1, -64'sd1, -64'sd1, 1'b1);
    send_item(0, 0, MinVal, MaxVal, 1'b0);
    send_item(MinVal, MinVal, 0, -1, 1'b0);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      repeat (385) send_random();
    end
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("interval_int_div_bounds: match");
    end else begin
      $display("interval_int_div_bounds: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("interval_int_div_bounds: mismatch");
    $finish;
  end
endmodule
